@@ rtl/sll_pkg.sv @@
package sll_pkg;

   // list storage
   localparam int CAPACITY = 1024;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int LINK_W   = SLOT_W + 1;
   localparam int CNT_W    = SLOT_W + 1;

   // beat field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 11;
   localparam int DATA_W   = 32;

   localparam logic [LINK_W-1:0] NIL_LINK = '1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_HEAD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TAIL_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POS_INSERT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOCATE      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GET         = 3'd5;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LINK_W-1:0]  link;
   } slot_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  addr;
      logic               we_value;
      logic               we_link;
      logic [VALUE_W-1:0] value;
      logic [LINK_W-1:0]  link;
   } wr_type;

   // out-of-range links fall back to slot zero
   function automatic logic [SLOT_W-1:0] safe_slot(input logic [LINK_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = (s < LINK_W'(CAPACITY)) ? s[SLOT_W-1:0] : '0;
      return r;
   endfunction

endpackage

@@ rtl/static_linked_list_engine_top.sv @@
// Ordered list of up to 1024 signed 32-bit values kept in a slot memory
// (value and next-link per slot). A command is taken when start is high and
// busy is low; exactly one result beat follows, shown for one cycle with
// rsp_valid high, and the receiver cannot stall it. Head inserts and
// position-1 inserts need no walk. Commands that need position k walk the
// link chain one slot per cycle through the single read port of the slot
// memory; a tail insert walks to the last element of a non-empty list, and
// locate walks until it finds the value or reaches the end. Rejected
// commands (bad position, full list, unused code) and locate on an empty
// list answer from idle without raising busy. Deleted slots go onto a
// free list and are reused first; never-used slots are handed out in order.
// No clearing pass is needed after reset: a slot is always written before
// any walk can reach it. Each command finishes all its writes before busy
// drops, so back-to-back commands never race on the same slot.
module static_linked_list_engine_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sll_pkg::CMD_W-1:0]        req_command,
   input  logic [sll_pkg::POS_W-1:0]        req_position,
   input  logic signed [sll_pkg::DATA_W-1:0] req_item_value,
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic signed [sll_pkg::DATA_W-1:0] rsp_out_value,
   output logic [sll_pkg::POS_W-1:0]        rsp_found_position,
   output logic [sll_pkg::POS_W-1:0]        rsp_list_length
);
   import sll_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_LOC,
      S_ALLOC,
      S_PLACE,
      S_LINK,
      S_FREE
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [LINK_W-1:0]   free_ff, free_in;
   logic [CNT_W-1:0]    unused_ff, unused_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // command and walk payload
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   prev_ff, prev_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [LINK_W-1:0]   link_p_ff, link_p_in;
   logic                after_ff, after_in;
   logic [SLOT_W-1:0]   new_ff, new_in;
   logic [VALUE_W-1:0]  hold_val_ff, hold_val_in;

   // result beat
   logic                rsp_ok_ff, rsp_ok_in;
   logic [DATA_W-1:0]   rsp_val_ff, rsp_val_in;
   logic [POS_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]    rsp_len_ff, rsp_len_in;

   // slot memory port
   logic [SLOT_W-1:0]   rd_addr;
   slot_type            rd_data;
   wr_type              wr;

   logic                full;
   logic                pos_in_list;
   logic                pos_insertable;
   logic [SLOT_W-1:0]   take_slot;

   sll_mem u_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   assign full           = (count_ff == CNT_W'(CAPACITY));
   assign pos_in_list    = (req_position != '0) && (int'(req_position) <= int'(count_ff));
   assign pos_insertable = (req_position != '0) && (int'(req_position) <= int'(count_ff) + 1);
   assign take_slot      = (free_ff != NIL_LINK) ? safe_slot(free_ff) : safe_slot(unused_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      unused_in    = unused_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      idx_in       = idx_ff;
      link_p_in    = link_p_ff;
      after_in     = after_ff;
      new_in       = new_ff;
      hold_val_in  = hold_val_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_val_in   = '0;
      rsp_found_in = '0;
      rd_addr      = safe_slot(head_ff);
      wr           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_command;
               pos_in = req_position;
               val_in = req_item_value;
               // the head slot read goes out now for any walk
               cur_in = safe_slot(head_ff);
               idx_in = CNT_W'(1);
               unique case (req_command) inside
                  CMD_HEAD_INSERT: begin
                     if (!full) begin
                        after_in = 1'b0;
                        state_in = S_ALLOC;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_TAIL_INSERT: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == '0) begin
                        after_in = 1'b0;
                        state_in = S_ALLOC;
                     end else begin
                        after_in = 1'b1;
                        steps_in = count_ff - CNT_W'(1);
                        state_in = S_WALK;
                     end
                  end
                  CMD_POS_INSERT: begin
                     if (full || !pos_insertable) begin
                        rsp_valid_in = 1'b1;
                     end else if (req_position == POS_W'(1)) begin
                        after_in = 1'b0;
                        state_in = S_ALLOC;
                     end else begin
                        after_in = 1'b1;
                        steps_in = CNT_W'(req_position - POS_W'(2));
                        state_in = S_WALK;
                     end
                  end
                  CMD_DELETE, CMD_GET: begin
                     if (pos_in_list) begin
                        steps_in = CNT_W'(req_position - POS_W'(1));
                        state_in = S_WALK;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_LOCATE: begin
                     if (count_ff != '0 && head_ff != NIL_LINK) begin
                        state_in = S_LOC;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_WALK: begin
            if (steps_ff != '0) begin
               // one hop a cycle: next address straight from the read data
               rd_addr  = safe_slot(rd_data.link);
               prev_in  = cur_ff;
               cur_in   = safe_slot(rd_data.link);
               steps_in = steps_ff - CNT_W'(1);
            end else begin
               unique case (cmd_ff) inside
                  CMD_GET: begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b1;
                     rsp_val_in   = rd_data.value;
                     state_in     = S_IDLE;
                  end
                  CMD_DELETE: begin
                     // cur is the victim, prev its predecessor
                     hold_val_in = rd_data.value;
                     new_in      = cur_ff;
                     if (pos_ff == POS_W'(1)) begin
                        head_in = rd_data.link;
                     end else begin
                        wr.addr    = prev_ff;
                        wr.we_link = 1'b1;
                        wr.link    = rd_data.link;
                     end
                     state_in = S_FREE;
                  end
                  default: begin
                     // insert after cur
                     prev_in   = cur_ff;
                     link_p_in = rd_data.link;
                     state_in  = S_ALLOC;
                  end
               endcase
            end
         end

         S_LOC: begin
            if (rd_data.value == val_ff) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_found_in = POS_W'(idx_ff);
               state_in     = S_IDLE;
            end else if (idx_ff == count_ff || rd_data.link == NIL_LINK) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_addr = safe_slot(rd_data.link);
               idx_in  = idx_ff + CNT_W'(1);
            end
         end

         S_ALLOC: begin
            // fetch the free list successor
            rd_addr  = safe_slot(free_ff);
            state_in = S_PLACE;
         end

         S_PLACE: begin
            if (free_ff != NIL_LINK) begin
               free_in = rd_data.link;
            end else if (int'(unused_ff) < CAPACITY) begin
               unused_in = unused_ff + CNT_W'(1);
            end
            wr.addr     = take_slot;
            wr.we_value = 1'b1;
            wr.we_link  = 1'b1;
            wr.value    = val_ff;
            wr.link     = after_ff ? link_p_ff : head_ff;
            count_in    = count_ff + CNT_W'(1);
            if (after_ff) begin
               new_in   = take_slot;
               state_in = S_LINK;
            end else begin
               head_in      = LINK_W'(take_slot);
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_LINK: begin
            wr.addr      = prev_ff;
            wr.we_link   = 1'b1;
            wr.link      = LINK_W'(new_ff);
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            state_in     = S_IDLE;
         end

         S_FREE: begin
            // victim goes on top of the free list
            wr.addr      = new_ff;
            wr.we_link   = 1'b1;
            wr.link      = free_ff;
            free_in      = LINK_W'(new_ff);
            count_in     = count_ff - CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_val_in   = hold_val_ff;
            state_in     = S_IDLE;
         end
      endcase

      rsp_len_in = POS_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL_LINK;
         count_ff     <= '0;
         free_ff      <= NIL_LINK;
         unused_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         unused_ff    <= unused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      steps_ff     <= steps_in;
      idx_ff       <= idx_in;
      link_p_ff    <= link_p_in;
      after_ff     <= after_in;
      new_ff       <= new_in;
      hold_val_ff  <= hold_val_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_found_ff <= rsp_found_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_out_value      = rsp_val_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_len_ff;

endmodule

@@ rtl/sll_mem.sv @@
module sll_mem (
   input  logic                         clock,
   input  logic [sll_pkg::SLOT_W-1:0]   rd_addr,
   output sll_pkg::slot_type            rd_data,
   input  sll_pkg::wr_type              wr
);
   import sll_pkg::*;

   logic [VALUE_W-1:0] value_mem [CAPACITY];
   logic [LINK_W-1:0]  link_mem  [CAPACITY];
   slot_type           rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we_value) begin
         value_mem[wr.addr] <= wr.value;
      end
      if (wr.we_link) begin
         link_mem[wr.addr] <= wr.link;
      end
      rd_data_ff.value <= value_mem[rd_addr];
      rd_data_ff.link  <= link_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sll_checker.sv @@
module sll_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic                              rsp_ok,
   input logic [sll_pkg::POS_W-1:0]         rsp_found_position,
   input logic [sll_pkg::POS_W-1:0]         rsp_list_length
);

   // reset leaves the engine idle with no beat pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("engine not idle after reset");

   // an accepted command either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command dropped");

   // a result beat only follows work or an accept
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result beat without a command");

   // a found position is a successful hit inside the list
   a_found_in_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found_position != '0) |->
         (rsp_ok && rsp_found_position <= rsp_list_length))
      else $error("found position outside list");

endmodule

bind static_linked_list_engine_top sll_checker u_sll_checker (.*);
